// ===== hw/rtl/lvem_pkg.sv =====
package lvem_pkg;

  // Fixed field widths
  localparam int LEVEL_W = 32;
  localparam int RATE_W  = 24;
  localparam int STEP_W  = 20;
  localparam int SUM_W   = 48;
  localparam int OPND_W  = LEVEL_W + 1;   // multiplier operand, signed
  localparam int PROD_W  = 2 * OPND_W;    // full product

  localparam int IN_DATA_W  = 88;         // 84 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 112;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 32'sh7fff_ffff;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 32'sh8000_0000;
  localparam logic [SUM_W-1:0]          SUM_MAX   = 48'h8000_0000_0000;

  // Register file
  localparam logic [1:0] REG_PREY_GROWTH    = 2'd0;
  localparam logic [1:0] REG_PREDATION_RATE = 2'd1;
  localparam logic [1:0] REG_PREDATOR_DEATH = 2'd2;
  localparam logic [1:0] REG_PREDATOR_GAIN  = 2'd3;

  localparam logic signed [RATE_W-1:0] PREY_GROWTH_RST    = 24'sd1310720;
  localparam logic signed [RATE_W-1:0] PREDATION_RATE_RST = 24'sd262144;
  localparam logic signed [RATE_W-1:0] PREDATOR_DEATH_RST = 24'sd262144;
  localparam logic signed [RATE_W-1:0] PREDATOR_GAIN_RST  = 24'sd262144;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_MUL_BY   = 11'b000_0000_0010,
    ST_MUL_DX   = 11'b000_0000_0100,
    ST_MUL_XS   = 11'b000_0000_1000,
    ST_MUL_YS   = 11'b000_0001_0000,
    ST_MUL_DTP  = 11'b000_0010_0000,
    ST_MUL_DTQ  = 11'b000_0100_0000,
    ST_NEW_PRED = 11'b000_1000_0000,
    ST_MUL_SQ   = 11'b001_0000_0000,
    ST_SUM      = 11'b010_0000_0000,
    ST_OUT      = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic                      ovf;
    logic signed [LEVEL_W-1:0] val;
  } clamp_t;

  // Clamp a wide signed value into the level range, flagging a clamp
  function automatic clamp_t clamp_level(input logic signed [PROD_W-1:0] v);
    clamp_t r;
    if (v > PROD_W'(LEVEL_MAX)) begin
      r.ovf = 1'b1;
      r.val = LEVEL_MAX;
    end else if (v < PROD_W'(LEVEL_MIN)) begin
      r.ovf = 1'b1;
      r.val = LEVEL_MIN;
    end else begin
      r.ovf = 1'b0;
      r.val = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lotka_volterra_euler_misfit.sv =====
// Forward-Euler predator-prey model scored against a stream of observations.
// Input words (s_t*): s_tuser carries first_sample, s_tdata the step time and
// the observed prey and predator levels. A word with first_sample set seeds
// the model from the observation and clears the misfit sum and the saturated
// flag; any other word advances the model one Euler step with its own step
// time and adds half the squared prey misfit to the running sum.
// Output words (m_t*): one per input word, the model levels, the negated sum
// as log likelihood, and the saturated flag in m_tuser.
// Sequencing: a seeding word goes from idle straight to the output step; a
// stepping word forms seven products that go one at a time through the
// single 33x33 multiplier; each of the first six is followed by a clamp/add
// step in the shared post unit and the square by the add into the misfit
// sum. The prey and predator chains are interleaved so one chain's post
// step overlaps the other's multiply. s_tready is high only while the
// sequencer is idle, so a word is taken only once the last has left it.
// The output register decouples the sides: a new word may be accepted while
// a result waits; if m_tready stays low the finished next result holds in
// the last step until the register frees.
// Reset (rst, synchronous) loads the rate registers with their defaults and
// zeroes the levels, the sum and the flag. Rates are written through the APB
// port at byte address 4*index and should change only while idle.
module lotka_volterra_euler_misfit
  import lvem_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // step_time[19:0], obs_prey[51:20],
                                           // obs_predator[83:52], zero pad
  input  logic [0:0]            s_tuser,   // first_sample[0]
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // model_prey[31:0],
                                           // model_predator[63:32],
                                           // log_likelihood[111:64]
  output logic [0:0]            m_tuser,   // saturated[0]
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t state, state_next;

  logic signed [RATE_W-1:0]  prey_growth, predation_rate, predator_death, predator_gain;
  logic signed [LEVEL_W-1:0] prey_level, predator_level;
  logic [SUM_W-1:0]          misfit_sum;
  logic                      overflow_seen;

  logic [STEP_W-1:0]         step_time;
  logic signed [LEVEL_W-1:0] obs_prey;
  logic signed [LEVEL_W-1:0] tmp_a, tmp_b;     // prey / predator chain temps
  logic signed [OPND_W-1:0]  diff;

  logic signed [OPND_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [PROD_W-1:0]  shifted, addend, post_sum;
  logic                      post_sub;
  clamp_t                    post;

  logic [PROD_W-1:0]         half;
  logic [SUM_W-1:0]          room;
  logic                      sum_over;

  logic in_acc, cfg_wr, out_free;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prey_growth    <= PREY_GROWTH_RST;
      predation_rate <= PREDATION_RATE_RST;
      predator_death <= PREDATOR_DEATH_RST;
      predator_gain  <= PREDATOR_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PREY_GROWTH:    prey_growth    <= $signed(pwdata[RATE_W-1:0]);
        REG_PREDATION_RATE: predation_rate <= $signed(pwdata[RATE_W-1:0]);
        REG_PREDATOR_DEATH: predator_death <= $signed(pwdata[RATE_W-1:0]);
        REG_PREDATOR_GAIN:  predator_gain  <= $signed(pwdata[RATE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PREY_GROWTH:    prdata = CFG_DATA_W'($unsigned(prey_growth));
      REG_PREDATION_RATE: prdata = CFG_DATA_W'($unsigned(predation_rate));
      REG_PREDATOR_DEATH: prdata = CFG_DATA_W'($unsigned(predator_death));
      REG_PREDATOR_GAIN:  prdata = CFG_DATA_W'($unsigned(predator_gain));
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_acc) state_next = s_tuser[0] ? ST_OUT : ST_MUL_BY;
      ST_MUL_BY:   state_next = ST_MUL_DX;
      ST_MUL_DX:   state_next = ST_MUL_XS;
      ST_MUL_XS:   state_next = ST_MUL_YS;
      ST_MUL_YS:   state_next = ST_MUL_DTP;
      ST_MUL_DTP:  state_next = ST_MUL_DTQ;
      ST_MUL_DTQ:  state_next = ST_NEW_PRED;
      ST_NEW_PRED: state_next = ST_MUL_SQ;
      ST_MUL_SQ:   state_next = ST_SUM;
      ST_SUM:      state_next = ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------------
  // Shared multiplier: operands chosen by step, product registered
  // ---------------------------------------------------------------------
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      ST_MUL_BY: begin  // b * predator
        op_a = OPND_W'(predation_rate);
        op_b = OPND_W'(predator_level);
      end
      ST_MUL_DX: begin  // d * prey
        op_a = OPND_W'(predator_gain);
        op_b = OPND_W'(prey_level);
      end
      ST_MUL_XS: begin  // prey * (a - b*pred)
        op_a = OPND_W'(prey_level);
        op_b = OPND_W'(tmp_a);
      end
      ST_MUL_YS: begin  // predator * (c - d*prey)
        op_a = OPND_W'(predator_level);
        op_b = OPND_W'(tmp_b);
      end
      ST_MUL_DTP: begin
        op_a = $signed(OPND_W'(step_time));
        op_b = OPND_W'(tmp_a);
      end
      ST_MUL_DTQ: begin
        op_a = $signed(OPND_W'(step_time));
        op_b = OPND_W'(tmp_b);
      end
      ST_MUL_SQ: begin
        op_a = diff;
        op_b = diff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // ---------------------------------------------------------------------
  // Shared post unit: floor shift of the last product, add or subtract,
  // clamp to the level range
  // ---------------------------------------------------------------------
  assign shifted = prod >>> FRAC_BITS;

  always_comb begin
    addend   = '0;
    post_sub = 1'b0;
    unique case (state)
      ST_MUL_DX: begin
        addend   = PROD_W'(prey_growth);
        post_sub = 1'b1;
      end
      ST_MUL_XS: begin
        addend   = PROD_W'(predator_death);
        post_sub = 1'b1;
      end
      ST_MUL_DTQ:  addend = PROD_W'(prey_level);
      ST_NEW_PRED: begin
        addend   = PROD_W'(predator_level);
        post_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign post_sum = post_sub ? (addend - shifted) : (addend + shifted);
  assign post     = clamp_level(post_sum);

  // Half square of the misfit, and headroom left under the sum ceiling
  assign half     = $unsigned(prod) >> (FRAC_BITS + 1);
  assign room     = SUM_MAX - misfit_sum;
  assign sum_over = half > PROD_W'(room);

  // ---------------------------------------------------------------------
  // Model state and working registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prey_level     <= '0;
      predator_level <= '0;
      misfit_sum     <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && s_tuser[0]) begin
            prey_level     <= $signed(s_tdata[51:20]);
            predator_level <= $signed(s_tdata[83:52]);
            misfit_sum     <= '0;
            overflow_seen  <= 1'b0;
          end
        end
        ST_MUL_DX, ST_MUL_XS, ST_MUL_YS, ST_MUL_DTP: begin
          if (post.ovf) overflow_seen <= 1'b1;
        end
        ST_MUL_DTQ: begin
          prey_level <= post.val;
          if (post.ovf) overflow_seen <= 1'b1;
        end
        ST_NEW_PRED: begin
          predator_level <= post.val;
          if (post.ovf) overflow_seen <= 1'b1;
        end
        ST_SUM: begin
          if (sum_over) begin
            misfit_sum    <= SUM_MAX;
            overflow_seen <= 1'b1;
          end else begin
            misfit_sum <= misfit_sum + half[SUM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      step_time <= s_tdata[19:0];
      obs_prey  <= $signed(s_tdata[51:20]);
    end
    unique case (state)
      ST_MUL_DX:   tmp_a <= post.val;   // a - b*pred
      ST_MUL_XS:   tmp_b <= post.val;   // c - d*prey
      ST_MUL_YS:   tmp_a <= post.val;   // prey * (...)
      ST_MUL_DTP:  tmp_b <= post.val;   // predator * (...)
      ST_NEW_PRED: diff  <= OPND_W'(obs_prey) - OPND_W'(prey_level);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {SUM_W'(0) - misfit_sum, predator_level, prey_level};
      m_tuser <= overflow_seen;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_seed_fast: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser[0] |=> state == ST_OUT)
    else $error("seeding word did not go straight to output");

  a_sum_ceiling: assert property (@(posedge clk) disable iff (rst)
    misfit_sum <= SUM_MAX)
    else $error("misfit sum above ceiling");

  a_flag_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(overflow_seen) |-> $past(in_acc && s_tuser[0]))
    else $error("saturated flag cleared without seeding");

  a_sum_drop: assert property (@(posedge clk) disable iff (rst)
    (misfit_sum < $past(misfit_sum)) |-> $past(in_acc && s_tuser[0]))
    else $error("misfit sum decreased without seeding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && !out_free |=> state == ST_OUT)
    else $error("result left the sequencer while output was full");

endmodule

// ===== sim/tb_lotka_volterra_euler_misfit.sv =====
module tb_lotka_volterra_euler_misfit
  import lvem_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam longint unsigned SUM_CAP = SUM_MAX;

  // One observation word and one model result word, as the predictor sees them
  typedef struct packed {
    logic                      first;
    logic [STEP_W-1:0]         dt;
    logic signed [LEVEL_W-1:0] ox;
    logic signed [LEVEL_W-1:0] oy;
  } obs_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] prey;
    logic [LEVEL_W-1:0] pred;
    logic [SUM_W-1:0]   loglik;
    logic               sat;
  } result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // step_time, obs_prey, obs_predator, pad
  logic [0:0]            s_tuser = '0;   // first_sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // model_prey, model_predator, log_likelihood
  logic [0:0]            m_tuser;        // saturated
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lotka_volterra_euler_misfit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Observation words waiting to go out, and model results still owed by the block
  obs_t    obs_q[$];
  result_t model_q[$];

  int words_queued = 0;
  int words_taken  = 0;
  int mismatch_cnt = 0;

  // Handshake flags sampled at the rising edge, read by the drivers at the falling edge
  bit word_taken   = 1'b0;
  bit result_taken = 1'b0;

  // Per-word idle counts, with occasional stretches of back-to-back traffic
  int send_wait = 0;
  int recv_wait = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;

  // Shadow of the rate registers and of the model state
  logic signed [RATE_W-1:0] rate_a = PREY_GROWTH_RST;
  logic signed [RATE_W-1:0] rate_b = PREDATION_RATE_RST;
  logic signed [RATE_W-1:0] rate_c = PREDATOR_DEATH_RST;
  logic signed [RATE_W-1:0] rate_d = PREDATOR_GAIN_RST;
  longint          lv_prey    = 0;
  longint          lv_pred    = 0;
  longint unsigned misfit_acc = 0;
  bit              sat_seen   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #15ms;
    $display("Test completed with failures");
    $finish;
  end

  // Clamp to the 32-bit level range; any clamp marks the run as saturated
  function automatic longint clip_level(longint v);
    if (v > longint'(LEVEL_MAX)) begin
      sat_seen = 1'b1;
      return longint'(LEVEL_MAX);
    end
    if (v < longint'(LEVEL_MIN)) begin
      sat_seen = 1'b1;
      return longint'(LEVEL_MIN);
    end
    return v;
  endfunction

  // dt * lvl * (rate - coef * other), every product floored back to FRAC_BITS
  function automatic longint euler_delta(longint lvl, longint other, longint rate,
                                         longint coef, longint dt);
    longint s;
    longint p;
    s = clip_level(rate - ((coef * other) >>> FRAC_BITS));
    p = clip_level((lvl * s) >>> FRAC_BITS);
    return (dt * p) >>> FRAC_BITS;
  endfunction

  // Advance the shadow model by one observation and return the result it owes
  function automatic result_t advance_model(obs_t o);
    result_t         r;
    longint          x;
    longint          y;
    longint          dx;
    longint          dy;
    longint          diff;
    longint unsigned mag;
    longint unsigned half;
    if (o.first) begin
      // seed: copy the observation, clear the sum and the flag
      lv_prey    = longint'(o.ox);
      lv_pred    = longint'(o.oy);
      misfit_acc = 0;
      sat_seen   = 1'b0;
    end else begin
      x  = lv_prey;
      y  = lv_pred;
      dx = euler_delta(x, y, rate_a, rate_b, longint'(o.dt));
      dy = euler_delta(y, x, rate_c, rate_d, longint'(o.dt));
      lv_prey = clip_level(x + dx);
      lv_pred = clip_level(y - dy);
      // score prey only; the sum pins at its cap
      diff = longint'(o.ox) - lv_prey;
      mag  = (diff < 0) ? -diff : diff;
      half = (mag * mag) >> (FRAC_BITS + 1);
      if (half > SUM_CAP - misfit_acc) begin
        misfit_acc = SUM_CAP;
        sat_seen   = 1'b1;
      end else begin
        misfit_acc = misfit_acc + half;
      end
    end
    r.prey   = lv_prey[LEVEL_W-1:0];
    r.pred   = lv_pred[LEVEL_W-1:0];
    r.loglik = SUM_W'(64'd0 - misfit_acc);
    r.sat    = sat_seen;
    return r;
  endfunction

  // Rising edge: record handshakes, predict on every accepted input word,
  // check every accepted output word against the oldest prediction
  always @(posedge clk) begin : watch
    obs_t    o;
    result_t want;
    word_taken   = !rst && s_tvalid && s_tready;
    result_taken = !rst && m_tvalid && m_tready;
    if (word_taken) begin
      o.first = s_tuser[0];
      o.dt    = s_tdata[19:0];
      o.ox    = s_tdata[51:20];
      o.oy    = s_tdata[83:52];
      model_q.push_back(advance_model(o));
      words_taken++;
    end
    if (result_taken) begin
      if (model_q.size() == 0) begin
        $error("unexpected result word: model_prey %0d", $signed(m_tdata[31:0]));
        mismatch_cnt++;
      end else begin
        want = model_q.pop_front();
        if (m_tdata[31:0] !== want.prey) begin
          $error("model_prey: expected %0d, got %0d",
                 $signed(want.prey), $signed(m_tdata[31:0]));
          mismatch_cnt++;
        end
        if (m_tdata[63:32] !== want.pred) begin
          $error("model_predator: expected %0d, got %0d",
                 $signed(want.pred), $signed(m_tdata[63:32]));
          mismatch_cnt++;
        end
        if (m_tdata[111:64] !== want.loglik) begin
          $error("log_likelihood: expected %0d, got %0d",
                 $signed(want.loglik), $signed(m_tdata[111:64]));
          mismatch_cnt++;
        end
        if (m_tuser[0] !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, m_tuser[0]);
          mismatch_cnt++;
        end
      end
    end
  end

  // Input driver: hold a word until taken, then idle the drawn number of cycles
  always @(negedge clk) begin : send_side
    obs_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (obs_q.size() > 0) begin
        nxt = obs_q.pop_front();
        s_tdata  <= {4'b0, nxt.oy, nxt.ox, nxt.dt};
        s_tuser  <= nxt.first;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
        send_wait = send_steady ? 0 : $urandom_range(0, 10);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side: stall a drawn number of cycles after each taken result
  always @(negedge clk) begin : recv_side
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (result_taken) begin
        if ($urandom_range(0, 49) == 0) recv_steady = !recv_steady;
        recv_wait = recv_steady ? 0 : $urandom_range(0, 10);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_obs(input logic first, input logic [STEP_W-1:0] dt,
                          input logic signed [LEVEL_W-1:0] ox,
                          input logic signed [LEVEL_W-1:0] oy);
    obs_t o;
    o.first = first;
    o.dt    = dt;
    o.ox    = ox;
    o.oy    = oy;
    obs_q.push_back(o);
    words_queued++;
  endtask

  // Mostly plausible levels, with full-range values and the extremes mixed in
  function automatic logic signed [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return LEVEL_MAX;
      2:       return LEVEL_MIN;
      3:       return 32'sd0 - $urandom_range(0, 32'h0040_0000);
      default: return $urandom_range(0, 32'h00C8_0000);
    endcase
  endfunction

  // Mostly short steps so the model evolves instead of clamping at once
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return STEP_W'($urandom_range(0, 20'hFFFFF));
      1:       return '0;
      default: return STEP_W'($urandom_range(1, 3000));
    endcase
  endfunction

  // Seed followed by a run of Euler steps, with some bare noise words between
  task automatic queue_random(input int n);
    int made;
    int len;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_obs(1'($urandom_range(0, 1)), STEP_W'($urandom_range(0, 20'hFFFFF)),
                 $urandom, $urandom);
        made++;
      end else begin
        len = $urandom_range(1, 30);
        push_obs(1'b1, STEP_W'($urandom_range(0, 20'hFFFFF)), pick_level(), pick_level());
        repeat (len) push_obs(1'b0, pick_step(), pick_level(), pick_level());
        made += len + 1;
      end
    end
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic wait_drained();
    while (words_taken != words_queued || model_q.size() != 0) @(negedge clk);
  endtask

  // APB write: setup, then access; the register loads at the access edge
  task automatic write_rate(input logic [1:0] idx, input logic [RATE_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= {{(CFG_DATA_W-RATE_W){val[RATE_W-1]}}, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PREY_GROWTH:    rate_a = val;
      REG_PREDATION_RATE: rate_b = val;
      REG_PREDATOR_DEATH: rate_c = val;
      REG_PREDATOR_GAIN:  rate_d = val;
      default: ;
    endcase
  endtask

  task automatic write_rates(input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] b,
                             input logic [RATE_W-1:0] c, input logic [RATE_W-1:0] d);
    write_rate(REG_PREY_GROWTH, a);
    write_rate(REG_PREDATION_RATE, b);
    write_rate(REG_PREDATOR_DEATH, c);
    write_rate(REG_PREDATOR_GAIN, d);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words on the reset rates
    // step before any seed: the model starts from zero levels
    push_obs(1'b0, 20'hFFFFF, LEVEL_MIN, LEVEL_MAX);
    // seed at the extremes; the step time must be ignored
    push_obs(1'b1, 20'hFFFFF, LEVEL_MAX, LEVEL_MIN);
    // longest step from the extremes: clamps and a saturating misfit
    push_obs(1'b0, 20'hFFFFF, LEVEL_MIN, LEVEL_MAX);
    push_obs(1'b0, 20'h00001, 32'sd0, 32'sd0);
    // reseed clears the sum and the flag
    push_obs(1'b1, 20'h00000, 32'sd0, 32'sd0);
    push_obs(1'b0, 20'h00000, 32'sd0, 32'sd0);
    push_obs(1'b0, 20'hFFFFF, 32'sd0, 32'sd0);
    // ordinary trajectory: prey 10.0, predator 2.0, step 0.01
    push_obs(1'b1, 20'h00000, 32'sd655360, 32'sd131072);
    repeat (6) push_obs(1'b0, 20'd655, 32'sd655360, 32'sd131072);
    // negative levels
    push_obs(1'b1, 20'hFFFFF, -32'sd327680, -32'sd196608);
    repeat (3) push_obs(1'b0, 20'd6554, -32'sd327680, 32'sd0);
    // both levels at the minimum
    push_obs(1'b1, 20'h00000, LEVEL_MIN, LEVEL_MIN);
    push_obs(1'b0, 20'hFFFFF, LEVEL_MAX, LEVEL_MIN);
    push_obs(1'b0, 20'h80000, LEVEL_MAX, LEVEL_MAX);
    wait_drained();

    // Modest rates: 1.0, 0.1, 1.5, 0.075
    write_rates(24'd65536, 24'd6554, 24'd98304, 24'd4915);
    queue_random(450);
    wait_drained();

    // Largest positive rates
    write_rates(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    queue_random(250);
    wait_drained();

    // Most negative rates
    write_rates(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    queue_random(250);
    wait_drained();

    // Arbitrary rates
    write_rates(RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom),
                RATE_W'($urandom));
    queue_random(400);
    wait_drained();

    // Back to the power-on rates
    write_rates(PREY_GROWTH_RST, PREDATION_RATE_RST, PREDATOR_DEATH_RST,
                PREDATOR_GAIN_RST);
    queue_random(400);
    wait_drained();

    // Let any stray output surface before deciding
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
